### hdl/mavg_pkg.sv
package mavg_pkg;

    // fixed sizes of the ring and its arithmetic
    localparam int MAX_WINDOW = 32;
    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 6;
    localparam int PTR_W      = 5;
    localparam int TOTAL_W    = 21;
    localparam int LB_W       = 16;
    localparam int DIV_STEPS  = TOTAL_W;
    localparam int STEP_W     = 5;

    // item kinds
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_LOOK = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_LB_RD,
        ST_FILL,
        ST_DONE
    } state_t;

    // status from the shared divider
    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] quotient;
        logic [LEN_W-1:0]   remainder;
    } div_result_t;

endpackage

### hdl/mavg_div.sv
module mavg_div
    import mavg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [TOTAL_W-1:0] dividend,
    input  logic [LEN_W-1:0]   divisor,
    output div_result_t        result
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [TOTAL_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [LEN_W-1:0]   dsr_reg, dsr_next;
    logic [LEN_W:0]     trial;
    logic [LEN_W:0]     diff;

    // one restoring step per cycle, quotient bits shift in at the bottom
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[TOTAL_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[LEN_W-1:0];
                quo_next = {quo_reg[TOTAL_W-2:0], 1'b1};
            end else begin
                rem_next = trial[LEN_W-1:0];
                quo_next = {quo_reg[TOTAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

### hdl/moving_average_window.sv
// Sliding-window average over the last window_length samples (1..32; 0 acts as
// 1, larger values as 32), kept in a 32-entry sample ring with a running total.
// One item is worked at a time and every item returns one result. An add and a
// lookback both run a bit-serial divider that retires one quotient bit per cycle
// over 21 steps (total / length, or lookback mod length). A fill writes one ring
// entry per cycle over the whole window; an unknown kind goes straight to its
// result. Writing window_length clears the ring, pointer, total and average at
// once (per-entry valid bits), so no clearing pass follows reset or a length
// change.
module moving_average_window
    import mavg_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [LEN_W-1:0]           cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_kind,
    input  logic signed [SAMPLE_W-1:0] s_value,
    input  logic [LB_W-1:0]            s_lookback,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_average,
    output logic signed [SAMPLE_W-1:0] m_history_sample
);

    state_t                      state_reg, state_next;
    logic [1:0]                  kind_reg, kind_next;
    logic [SAMPLE_W-1:0]         sample_reg, sample_next;
    logic [LB_W-1:0]             back_reg, back_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic [PTR_W-1:0]            wp_reg, wp_next;
    logic signed [TOTAL_W-1:0]   total_reg, total_next;
    logic [SAMPLE_W-1:0]         avg_reg, avg_next;
    logic [SAMPLE_W-1:0]         hist_reg, hist_next;
    logic [PTR_W-1:0]            fill_cnt_reg, fill_cnt_next;
    logic                        m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]         m_avg_reg, m_avg_next;
    logic [SAMPLE_W-1:0]         m_hist_reg, m_hist_next;
    logic [MAX_WINDOW-1:0]       valid_bits_reg, valid_bits_next;

    logic [SAMPLE_W-1:0]         ring [MAX_WINDOW];
    logic [SAMPLE_W-1:0]         rd_data_reg;
    logic                        rd_hit_reg;
    logic [SAMPLE_W-1:0]         rd_sample;
    logic                        rd_en;
    logic [PTR_W-1:0]            rd_addr;
    logic                        wr_en;
    logic [PTR_W-1:0]            wr_addr;

    logic [LEN_W-1:0]            len_eff;
    logic [LEN_W-1:0]            len_m1;
    logic [PTR_W-1:0]            newest;
    logic [LEN_W-1:0]            lb_k;
    logic [LEN_W-1:0]            lb_idx6;
    logic [PTR_W-1:0]            lb_idx;
    logic signed [TOTAL_W-1:0]   old_ext;
    logic signed [TOTAL_W-1:0]   new_ext;
    logic signed [TOTAL_W-1:0]   fill_total;
    logic [TOTAL_W-1:0]          total_mag;
    logic [SAMPLE_W-1:0]         quo16;

    logic                        div_start;
    logic [TOTAL_W-1:0]          div_dividend;
    div_result_t                 div_res;

    // effective window length
    always_comb begin
        if (len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_reg > LEN_W'(MAX_WINDOW)) begin
            len_eff = LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = len_reg;
        end
    end
    assign len_m1 = len_eff - LEN_W'(1);

    // lookback index from the remainder
    assign newest  = (wp_reg != '0) ? (wp_reg - PTR_W'(1)) : len_m1[PTR_W-1:0];
    assign lb_k    = div_res.remainder;
    assign lb_idx6 = (lb_k > {1'b0, newest}) ? (len_eff + {1'b0, newest} - lb_k)
                                               : ({1'b0, newest} - lb_k);
    assign lb_idx  = lb_idx6[PTR_W-1:0];

    // arithmetic on the running total
    assign rd_sample  = rd_hit_reg ? rd_data_reg : '0;
    assign old_ext    = $signed({{(TOTAL_W-SAMPLE_W){rd_sample[SAMPLE_W-1]}}, rd_sample});
    assign new_ext    = $signed({{(TOTAL_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg});
    assign fill_total = new_ext * $signed({{(TOTAL_W-LEN_W){1'b0}}, len_eff});
    assign total_mag  = total_reg[TOTAL_W-1] ? (~total_reg + TOTAL_W'(1)) : total_reg;
    assign quo16      = div_res.quotient[SAMPLE_W-1:0];

    // sequencer
    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        sample_next     = sample_reg;
        back_next       = back_reg;
        len_next        = len_reg;
        wp_next         = wp_reg;
        total_next      = total_reg;
        avg_next        = avg_reg;
        hist_next       = hist_reg;
        fill_cnt_next   = fill_cnt_reg;
        m_valid_next    = m_valid_reg;
        m_avg_next      = m_avg_reg;
        m_hist_next     = m_hist_reg;
        valid_bits_next = valid_bits_reg;
        s_ready         = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = wp_reg;
        wr_en           = 1'b0;
        wr_addr         = wp_reg;
        div_start       = 1'b0;
        div_dividend    = total_mag;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next     = s_kind;
                    sample_next   = s_value;
                    back_next     = s_lookback;
                    hist_next     = '0;
                    fill_cnt_next = '0;
                    unique case (s_kind)
                        KIND_ADD:  state_next = ST_ADD_RD;
                        KIND_FILL: state_next = ST_FILL;
                        KIND_LOOK: state_next = ST_DIV_GO;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADD_RD: begin
                rd_en      = 1'b1;
                state_next = ST_ADD_SUM;
            end
            ST_ADD_SUM: begin
                total_next              = total_reg - old_ext + new_ext;
                wr_en                   = 1'b1;
                valid_bits_next[wp_reg] = 1'b1;
                wp_next = ({1'b0, wp_reg} == len_m1) ? '0 : (wp_reg + PTR_W'(1));
                state_next              = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
                if (kind_reg == KIND_LOOK) begin
                    div_dividend = {{(TOTAL_W-LB_W){1'b0}}, back_reg};
                end
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_res.done) begin
                    if (kind_reg == KIND_LOOK) begin
                        rd_en      = 1'b1;
                        rd_addr    = lb_idx;
                        state_next = ST_LB_RD;
                    end else begin
                        avg_next   = total_reg[TOTAL_W-1] ? (~quo16 + SAMPLE_W'(1)) : quo16;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LB_RD: begin
                hist_next  = rd_sample;
                state_next = ST_DONE;
            end
            ST_FILL: begin
                wr_en                         = 1'b1;
                wr_addr                       = fill_cnt_reg;
                valid_bits_next[fill_cnt_reg] = 1'b1;
                fill_cnt_next                 = fill_cnt_reg + PTR_W'(1);
                if ({1'b0, fill_cnt_reg} == len_m1) begin
                    total_next = fill_total;
                    wp_next    = '0;
                    avg_next   = sample_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_avg_next   = avg_reg;
                    m_hist_next  = hist_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // length write restarts the window
        if (cfg_wr_en) begin
            len_next        = cfg_wr_data;
            wp_next         = '0;
            total_next      = '0;
            avg_next        = '0;
            valid_bits_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            len_reg        <= LEN_RESET;
            wp_reg         <= '0;
            total_reg      <= '0;
            avg_reg        <= '0;
            m_valid_reg    <= 1'b0;
            valid_bits_reg <= '0;
        end else begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            wp_reg         <= wp_next;
            total_reg      <= total_next;
            avg_reg        <= avg_next;
            m_valid_reg    <= m_valid_next;
            valid_bits_reg <= valid_bits_next;
        end
        kind_reg     <= kind_next;
        sample_reg   <= sample_next;
        back_reg     <= back_next;
        hist_reg     <= hist_next;
        fill_cnt_reg <= fill_cnt_next;
        m_avg_reg    <= m_avg_next;
        m_hist_reg   <= m_hist_next;
    end

    // sample ring, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wr_addr] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ring[rd_addr];
            rd_hit_reg  <= valid_bits_reg[rd_addr];
        end
    end

    // shared divider for averages and lookback reduction
    mavg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (len_eff),
        .result   (div_res)
    );

    assign m_valid          = m_valid_reg;
    assign m_average        = m_avg_reg;
    assign m_history_sample = m_hist_reg;

    // write pointer stays inside the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wp_reg} < len_eff)
        else $error("write pointer outside window");

    // an accepted item keeps the block busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !cfg_wr_en) |=> !s_ready)
        else $error("item accepted twice in a row");

    // divider finishes only while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider result without a waiting sequencer");

endmodule
